// File: design/sign_sketch_attention_score_defines.svh
// Assertion macros shared by the sign sketch score block.
`ifndef SIGN_SKETCH_ATTENTION_SCORE_DEFINES_SVH
`define SIGN_SKETCH_ATTENTION_SCORE_DEFINES_SVH

// Clocked check, quiet while reset is asserted.
`define SSAS_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define SSAS_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ssas_pkg.sv
package ssas_pkg;

	// Default sizes of the query store and of one key chunk
	localparam int QUERY_LEN_DEF  = 256;
	localparam int CHUNK_BITS_DEF = 64;

	// Field widths
	localparam int QIDX_W  = 8;
	localparam int QVAL_W  = 16;
	localparam int SIGN_W  = 64;
	localparam int CIDX_W  = 2;
	localparam int NORM_W  = 16;
	localparam int SCALE_W = 16;
	localparam int SCORE_W = 32;

	// Input tdata layout, lowest field first
	localparam int F_QIDX_LO  = 0;
	localparam int F_QVAL_LO  = F_QIDX_LO + QIDX_W;
	localparam int F_SIGN_LO  = F_QVAL_LO + QVAL_W;
	localparam int F_CIDX_LO  = F_SIGN_LO + SIGN_W;
	localparam int F_NORM_LO  = F_CIDX_LO + CIDX_W;
	localparam int IN_USED_W  = F_NORM_LO + NORM_W;
	localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

	// Output tdata: score, then the saturation flag
	localparam int OUT_USED_W  = SCORE_W + 1;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// One signed lane term is a query element or its negation
	localparam int TERM_W    = QVAL_W + 1;
	localparam int GRP_LANES = 8;

	// bf16 norm decoding
	localparam int EXP_W     = 8;
	localparam int FRAC_W    = 7;
	localparam int MAN_W     = FRAC_W + 1;
	localparam int SH_W      = $clog2(SCORE_W);
	localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'hFF;
	// Exponent at which the product needs no shift to reach Q19.12
	localparam logic [EXP_W-1:0] EXP_UNITY    = 8'd150;
	localparam logic [EXP_W-1:0] EXP_RSH_BASE = 8'd149;

	// Score limits
	localparam logic [SCORE_W-1:0] SCORE_POS_LIM = 32'h7FFF_FFFF;
	localparam logic [SCORE_W-1:0] SCORE_NEG_LIM = 32'h8000_0000;

	// Scale register reset: sqrt(pi/2)/256 in Q0.16
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd321;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_KEY  = 1'b1
	} op_t;

	// Request into the score pipeline
	typedef struct packed {
		logic              valid;
		logic [NORM_W-1:0] norm;
	} sc_req_t;

endpackage

// File: design/ssas_ram.sv
module ssas_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 4,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/ssas_lane.sv
module ssas_lane import ssas_pkg::*; #(
	parameter int LANE       = 0,
	parameter int CHUNK_BITS = CHUNK_BITS_DEF,
	parameter int QUERY_LEN  = QUERY_LEN_DEF
) (
	input  logic                     clk,
	input  logic                     load_we,
	input  logic [QIDX_W-1:0]        load_idx,
	input  logic [QVAL_W-1:0]        load_val,
	input  logic                     rd_en,
	input  logic [CIDX_W-1:0]        rd_row,
	input  logic [CIDX_W-1:0]        row_s1,
	input  logic                     sign_s1,
	output logic signed [TERM_W-1:0] term
);

	localparam int NUM_ROWS = 2 ** CIDX_W;

	logic [NUM_ROWS-1:0]      row_ok;
	logic [NUM_ROWS-1:0]      row_hit;
	logic [CIDX_W-1:0]        waddr;
	logic [QVAL_W-1:0]        q_s1;
	logic signed [TERM_W-1:0] q_ext;

	// Row r of this lane holds element r*CHUNK_BITS+LANE
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		localparam int ELEM = r * CHUNK_BITS + LANE;
		assign row_ok[r]  = (ELEM < QUERY_LEN);
		assign row_hit[r] = row_ok[r] && (int'(load_idx) == ELEM);
	end

	// Encode the matching row into a write address
	always_comb begin
		waddr = '0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (row_hit[r]) begin
				waddr = CIDX_W'(r);
			end
		end
	end

	ssas_ram #(
		.DATA_W(QVAL_W),
		.DEPTH (NUM_ROWS)
	) u_ram (
		.clk  (clk),
		.we   (load_we && (|row_hit)),
		.waddr(waddr),
		.wdata(load_val),
		.re   (rd_en),
		.raddr(rd_row),
		.rdata(q_s1)
	);

	// Add on a set sign bit, subtract on a clear one, drop elements past the store
	always_comb begin
		q_ext = TERM_W'(signed'(q_s1));
		if (!row_ok[row_s1]) begin
			term = '0;
		end else if (sign_s1) begin
			term = q_ext;
		end else begin
			term = -q_ext;
		end
	end

endmodule

// File: design/ssas_merge.sv
module ssas_merge import ssas_pkg::*; #(
	parameter int CHUNK_BITS = CHUNK_BITS_DEF,
	parameter int SUM_W      = TERM_W + $clog2(CHUNK_BITS_DEF) + 1
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [TERM_W-1:0] terms [CHUNK_BITS],
	output logic signed [SUM_W-1:0]  sum_s3
);

	localparam int NUM_GRP = (CHUNK_BITS + GRP_LANES - 1) / GRP_LANES;
	localparam int GS_W    = TERM_W + $clog2(GRP_LANES);

	logic signed [GS_W-1:0]  grp_sum [NUM_GRP];
	logic signed [GS_W-1:0]  grp_s2  [NUM_GRP];
	logic signed [SUM_W-1:0] total;

	// Sum each group of eight lanes
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_sum[g] = '0;
			for (int k = 0; k < GRP_LANES; k++) begin
				if (g * GRP_LANES + k < CHUNK_BITS) begin
					grp_sum[g] = grp_sum[g] + GS_W'(terms[g * GRP_LANES + k]);
				end
			end
		end
	end

	// Combine the registered group sums
	always_comb begin
		total = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			total = total + SUM_W'(grp_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s2 <= grp_sum;
			sum_s3 <= total;
		end
	end

endmodule

// File: design/ssas_score.sv
module ssas_score import ssas_pkg::*; #(
	parameter int ACC_W = QVAL_W + $clog2(QUERY_LEN_DEF) + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  sc_req_t                 req,
	input  logic signed [ACC_W-1:0] dot_s4,
	input  logic [SCALE_W-1:0]      scale,
	output logic                    res_valid,
	output logic [SCORE_W-1:0]      res_score,
	output logic                    res_sat
);

	localparam int P1_W   = ACC_W + MAN_W;
	localparam int P2_W   = P1_W + SCALE_W;
	localparam int WIDE_W = P2_W + SCORE_W;

	// Decode of the incoming dot and norm
	logic             dneg;
	logic [ACC_W-1:0] dmag;
	logic [EXP_W-1:0] ex;
	logic [EXP_W-1:0] exp_eff;
	logic [MAN_W-1:0] man;
	logic             special;
	logic             sp_zero;
	logic             neg;

	// Stage registers
	logic             v_s5, v_s6, v_s7;
	logic [P1_W-1:0]  prod1_s5;
	logic [P2_W-1:0]  prod2_s6;
	logic [P2_W-1:0]  pre_s7;
	logic [EXP_W-1:0] exp_s5, exp_s6;
	logic             neg_s5, neg_s6, neg_s7;
	logic             special_s5, special_s6, special_s7;
	logic             spz_s5, spz_s6, spz_s7;

	// Shift and rounding signals
	logic [EXP_W-1:0]   sh;
	logic [WIDE_W-1:0]  wide;
	logic               ovf;
	logic [SCORE_W-1:0] val;
	logic [P2_W-1:0]    pre;
	logic [P2_W:0]      rnd;
	logic [P2_W-1:0]    rmag;
	logic [SCORE_W-1:0] lim;

	// Split the dot into sign and magnitude, unpack the bf16 norm
	always_comb begin
		dneg    = dot_s4[ACC_W-1];
		dmag    = dneg ? $unsigned(-dot_s4) : $unsigned(dot_s4);
		ex      = req.norm[NORM_W-2 -: EXP_W];
		man     = (ex == '0) ? {1'b0, req.norm[FRAC_W-1:0]} : {1'b1, req.norm[FRAC_W-1:0]};
		exp_eff = (ex == '0) ? EXP_W'(1) : ex;
		special = (ex == EXP_ALL_ONES);
		sp_zero = (req.norm[FRAC_W-1:0] != '0) || (dmag == '0);
		neg     = dneg ^ req.norm[NORM_W-1];
	end

	// Shift the product to Q19.12: left at or above the unity exponent, else right keeping the round bit
	always_comb begin
		sh   = exp_s6 - EXP_UNITY;
		wide = WIDE_W'(prod2_s6) << sh[SH_W-1:0];
		ovf  = 1'b0;
		val  = '0;
		if (exp_s6 >= EXP_UNITY) begin
			if (sh >= EXP_W'(SCORE_W)) begin
				ovf = |prod2_s6;
			end else begin
				ovf = |wide[WIDE_W-1:SCORE_W];
				val = wide[SCORE_W-1:0];
			end
			pre = P2_W'({ovf, val, 1'b0});
		end else begin
			pre = prod2_s6 >> (EXP_RSH_BASE - exp_s6);
		end
	end

	// Round half away from zero on the magnitude, then saturate and sign
	always_comb begin
		rnd  = (P2_W + 1)'(pre_s7) + (P2_W + 1)'(1);
		rmag = rnd[P2_W:1];
		lim  = neg_s7 ? SCORE_NEG_LIM : SCORE_POS_LIM;
		if (special_s7) begin
			res_sat   = 1'b1;
			res_score = spz_s7 ? '0 : lim;
		end else if (rmag > P2_W'(lim)) begin
			res_sat   = 1'b1;
			res_score = lim;
		end else begin
			res_sat   = 1'b0;
			res_score = neg_s7 ? -rmag[SCORE_W-1:0] : rmag[SCORE_W-1:0];
		end
	end

	assign res_valid = v_s7;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= req.valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Multiply by the mantissa, then by the scale, then shift
	always_ff @(posedge clk) begin
		if (en) begin
			prod1_s5   <= P1_W'(dmag) * P1_W'(man);
			exp_s5     <= exp_eff;
			neg_s5     <= neg;
			special_s5 <= special;
			spz_s5     <= sp_zero;

			prod2_s6   <= P2_W'(prod1_s5) * P2_W'(scale);
			exp_s6     <= exp_s5;
			neg_s6     <= neg_s5;
			special_s6 <= special_s5;
			spz_s6     <= spz_s5;

			pre_s7     <= pre;
			neg_s7     <= neg_s6;
			special_s7 <= special_s6;
			spz_s7     <= spz_s6;
		end
	end

endmodule

// File: design/sign_sketch_attention_score.sv
// A last key chunk passes the lane read, group, chunk, dot, mantissa, scale, shift and output registers to m_tvalid.
// Throughput: one item per cycle, loads and key chunks alike; CHUNK_BITS lanes, each
// with its own small query RAM, feed a registered adder tree every cycle.
// Back-pressure on m_tready stalls the whole pipeline; s_tready follows it.
// Reset: arst_n clears valid bits, the dot accumulator and sets score_scale to 321;
// the query store holds no defined value until loaded.
`include "sign_sketch_attention_score_defines.svh"

module sign_sketch_attention_score import ssas_pkg::*; #(
	parameter int QUERY_LEN  = QUERY_LEN_DEF,
	parameter int CHUNK_BITS = CHUNK_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [SCALE_W-1:0]     cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// query_index, query_value, sign_bits, chunk_index, key_norm (low to high)
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// op
	input  logic [0:0]             s_tuser,
	// last_chunk
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// score, saturated (low to high)
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int ACC_W = QVAL_W + $clog2(QUERY_LEN) + 1;
	localparam int SUM_W = TERM_W + $clog2(CHUNK_BITS) + 1;

	logic                     en;
	logic                     in_xfer;
	logic                     load_we;
	logic                     key_xfer;
	logic [QIDX_W-1:0]        in_qidx;
	logic [QVAL_W-1:0]        in_qval;
	logic [CIDX_W-1:0]        in_cidx;
	logic [NORM_W-1:0]        in_norm;

	logic [SCALE_W-1:0]       scale_q;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic                     last_s1, last_s2, last_s3;
	logic [NORM_W-1:0]        norm_s1, norm_s2, norm_s3, norm_s4;
	logic [CIDX_W-1:0]        cidx_s1;
	logic [CHUNK_BITS-1:0]    sign_s1;

	logic signed [TERM_W-1:0] term [CHUNK_BITS];
	logic signed [SUM_W-1:0]  chunk_sum_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_next;
	logic signed [ACC_W-1:0]  dot_s4;

	sc_req_t                  req_s4;
	logic                     res_valid;
	logic [SCORE_W-1:0]       res_score;
	logic                     res_sat;

	logic                     out_valid_q;
	logic [OUT_TDATA_W-1:0]   out_data_q;

	// The pipeline advances whenever the output register is free or being drained
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign in_xfer  = s_tvalid && en;
	assign load_we  = in_xfer && (op_t'(s_tuser) == OP_LOAD);
	assign key_xfer = in_xfer && (op_t'(s_tuser) == OP_KEY);

	assign in_qidx = s_tdata[F_QIDX_LO +: QIDX_W];
	assign in_qval = s_tdata[F_QVAL_LO +: QVAL_W];
	assign in_cidx = s_tdata[F_CIDX_LO +: CIDX_W];
	assign in_norm = s_tdata[F_NORM_LO +: NORM_W];

	// Scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	// Lanes: one query element per sign bit
	for (genvar i = 0; i < CHUNK_BITS; i++) begin : g_lane
		ssas_lane #(
			.LANE      (i),
			.CHUNK_BITS(CHUNK_BITS),
			.QUERY_LEN (QUERY_LEN)
		) u_lane (
			.clk     (clk),
			.load_we (load_we),
			.load_idx(in_qidx),
			.load_val(in_qval),
			.rd_en   (key_xfer),
			.rd_row  (in_cidx),
			.row_s1  (cidx_s1),
			.sign_s1 (sign_s1[i]),
			.term    (term[i])
		);
	end

	ssas_merge #(
		.CHUNK_BITS(CHUNK_BITS),
		.SUM_W     (SUM_W)
	) u_merge (
		.clk   (clk),
		.en    (en),
		.terms (term),
		.sum_s3(chunk_sum_s3)
	);

	// Advance key valid bits and the accumulator
	assign acc_next = acc_q + ACC_W'(chunk_sum_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			acc_q <= '0;
		end else if (en) begin
			v_s1 <= key_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && last_s3;
			if (v_s3) begin
				acc_q <= last_s3 ? '0 : acc_next;
			end
		end
	end

	// Key payload along the lane and tree stages
	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= s_tlast;
			norm_s1 <= in_norm;
			cidx_s1 <= in_cidx;
			sign_s1 <= s_tdata[F_SIGN_LO +: CHUNK_BITS];
			last_s2 <= last_s1;
			norm_s2 <= norm_s1;
			last_s3 <= last_s2;
			norm_s3 <= norm_s2;
			norm_s4 <= norm_s3;
			dot_s4  <= acc_next;
		end
	end

	assign req_s4.valid = v_s4;
	assign req_s4.norm  = norm_s4;

	ssas_score #(
		.ACC_W(ACC_W)
	) u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.req      (req_s4),
		.dot_s4   (dot_s4),
		.scale    (scale_q),
		.res_valid(res_valid),
		.res_score(res_score),
		.res_sat  (res_sat)
	);

	// Output register; hold while the transfer is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= OUT_TDATA_W'({res_sat, res_score});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`SSAS_ASSERT_RST(a_rst_no_result, !arst_n |=> !out_valid_q, "result valid after reset")
	`SSAS_ASSERT_CLK(a_acc_clear, (en && v_s3 && last_s3) |=> (acc_q == '0), "acc not cleared")
	`SSAS_ASSERT_CLK(a_sat_limit, (out_valid_q && out_data_q[SCORE_W]) |-> ((out_data_q[SCORE_W-1:0] == '0) || (out_data_q[SCORE_W-1:0] == SCORE_POS_LIM) || (out_data_q[SCORE_W-1:0] == SCORE_NEG_LIM)), "saturated score off limit")
	`SSAS_ASSERT_CLK(a_stall_hold, !en |=> ($stable(v_s4) && $stable(acc_q)), "pipeline moved in stall")

endmodule

// File: sim/testbench.sv
module testbench;
	import ssas_pkg::*;

	// One input transfer, split into its fields
	typedef struct {
		op_t               op;
		logic [QIDX_W-1:0] qidx;
		logic [QVAL_W-1:0] qval;
		logic [SIGN_W-1:0] bits;
		logic [CIDX_W-1:0] chunk;
		logic [NORM_W-1:0] norm;
		logic              last;
	} sketch_item_t;

	// One score transfer
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               sat;
	} score_t;

	// Tracks the query sketch, the running sign dot product and the scores it implies
	class sign_dot_scorer;
		shortint            query_mem [QUERY_LEN_DEF];
		longint             dot_sum;
		logic [SCALE_W-1:0] scale;
		score_t             pending_scores [$];
		int                 mismatches;
		int                 scores_seen;
		int                 clipped_seen;

		function new();
			dot_sum = 0;
			scale = SCALE_RST;
			mismatches = 0;
			scores_seen = 0;
			clipped_seen = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		// Scale the dot product by the bf16 norm and score_scale, round, clip to Q19.12
		function score_t scaled_score(logic [NORM_W-1:0] norm);
			score_t            r;
			bit                dneg;
			bit                neg;
			longint unsigned   dmag;
			longint unsigned   mag;
			longint unsigned   lim;
			longint unsigned   man;
			logic [EXP_W-1:0]  ex;
			int                shift;
			dneg = dot_sum < 0;
			dmag = dneg ? -dot_sum : dot_sum;
			ex = norm[14:7];
			man = 64'(norm[6:0]);
			neg = dneg ^ norm[15];
			lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
			r.score = '0;
			r.sat = 1'b0;
			// Infinity clips toward the product's sign; NaN or a zero dot give zero
			if (ex == EXP_ALL_ONES) begin
				r.sat = 1'b1;
				if (man == 0 && dmag != 0)
					r.score = lim[SCORE_W-1:0];
				return r;
			end
			// Subnormals carry no hidden bit; 150 is the exponent that needs no shift
			if (ex == 0) begin
				shift = -149;
			end else begin
				man = man | 64'd128;
				shift = int'(ex) - 150;
			end
			mag = dmag * man * longint'(scale);
			if (mag == 0)
				return r;
			if (shift >= 0) begin
				if (shift >= 32 || mag > (lim >> shift)) begin
					r.score = lim[SCORE_W-1:0];
					r.sat = 1'b1;
					return r;
				end
				mag = mag << shift;
			end else begin
				// Round half away from zero on the magnitude
				if (-shift >= 64)
					mag = 0;
				else
					mag = (mag + (64'd1 << (-shift - 1))) >> (-shift);
				if (mag > lim) begin
					r.score = lim[SCORE_W-1:0];
					r.sat = 1'b1;
					return r;
				end
			end
			r.score = mag[SCORE_W-1:0];
			if (neg)
				r.score = -r.score;
			return r;
		endfunction

		// Apply one accepted transfer; queue a score when a key ends
		function void take_item(sketch_item_t it);
			int e;
			if (it.op == OP_LOAD) begin
				query_mem[it.qidx] = it.qval;
				return;
			end
			for (int i = 0; i < CHUNK_BITS_DEF; i++) begin
				e = int'(it.chunk) * CHUNK_BITS_DEF + i;
				if (e < QUERY_LEN_DEF) begin
					if (it.bits[i])
						dot_sum += query_mem[e];
					else
						dot_sum -= query_mem[e];
				end
			end
			if (it.last) begin
				pending_scores.push_back(scaled_score(it.norm));
				dot_sum = 0;
			end
		endfunction

		// Compare one result transfer against the oldest queued score
		task check_score(logic [SCORE_W-1:0] got_score, logic got_sat);
			score_t want;
			if (pending_scores.size() == 0) begin
				report($sformatf("score %h sat %b arrived with none pending", got_score, got_sat));
				return;
			end
			want = pending_scores.pop_front();
			scores_seen++;
			if (got_sat)
				clipped_seen++;
			if (got_score !== want.score)
				report($sformatf("score %h, want %h (score #%0d)", got_score, want.score,
					scores_seen));
			if (got_sat !== want.sat)
				report($sformatf("saturated %b, want %b (score #%0d)", got_sat, want.sat,
					scores_seen));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [SCALE_W-1:0]     cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// query_index, query_value, sign_bits, chunk_index, key_norm (low to high)
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	// op
	logic [0:0]             s_tuser = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// score, saturated (low to high)
	logic [OUT_TDATA_W-1:0] m_tdata;

	sign_dot_scorer scorer;
	bit             steady = 1'b0;
	bit             hold_req = 1'b0;
	int             hold_left = 0;
	int             loads_sent = 0;
	int             chunks_sent = 0;

	sign_sketch_attention_score DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	// End the run if the scores stop coming
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// Drive ready: long hold-off on request, steady stretch, else random stalls
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 34);
			end
		end
	end

	// Check every score transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			scorer.check_score(m_tdata[SCORE_W-1:0], m_tdata[SCORE_W]);
	end

	function automatic logic [IN_TDATA_W-1:0] pack_item(sketch_item_t it);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[F_QIDX_LO +: QIDX_W] = it.qidx;
		d[F_QVAL_LO +: QVAL_W] = it.qval;
		d[F_SIGN_LO +: SIGN_W] = it.bits;
		d[F_CIDX_LO +: CIDX_W] = it.chunk;
		d[F_NORM_LO +: NORM_W] = it.norm;
		return d;
	endfunction

	// Every field random, so fields an op ignores still toggle
	function automatic sketch_item_t random_item();
		sketch_item_t it;
		it.op = op_t'($urandom_range(1));
		it.qidx = QIDX_W'($urandom);
		it.qval = QVAL_W'($urandom);
		it.bits = {$urandom, $urandom};
		it.chunk = CIDX_W'($urandom);
		it.norm = NORM_W'($urandom);
		it.last = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic logic [SIGN_W-1:0] random_signs();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '1;
		if (r < 16)
			return '0;
		return {$urandom, $urandom};
	endfunction

	// Mostly ordinary norms, with specials and extremes mixed in
	function automatic logic [NORM_W-1:0] random_norm();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return {1'($urandom), 8'($urandom_range(140, 110)), 7'($urandom)};
		if (r < 75)
			return NORM_W'($urandom);
		if (r < 80)
			return {1'($urandom), EXP_ALL_ONES, 7'd0};
		if (r < 85)
			return {1'($urandom), EXP_ALL_ONES, 7'($urandom_range(127, 1))};
		if (r < 92)
			return {1'($urandom), 8'd0, 7'($urandom)};
		return {1'($urandom), 8'($urandom_range(254, 141)), 7'($urandom)};
	endfunction

	function automatic logic [QVAL_W-1:0] random_query();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 16'h7FFF;
		if (r < 10)
			return 16'h8000;
		return QVAL_W'($urandom);
	endfunction

	// Offer one transfer after random idle cycles; return at the next falling edge
	task automatic send_item(sketch_item_t it);
		while (!steady && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_item(it);
		s_tuser <= it.op;
		s_tlast <= it.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		scorer.take_item(it);
		if (it.op == OP_LOAD)
			loads_sent++;
		else
			chunks_sent++;
		@(negedge clk);
	endtask

	task automatic send_load(logic [QIDX_W-1:0] idx, logic [QVAL_W-1:0] val);
		sketch_item_t it;
		it = random_item();
		it.op = OP_LOAD;
		it.qidx = idx;
		it.qval = val;
		send_item(it);
	endtask

	task automatic send_chunk(logic [CIDX_W-1:0] chunk, logic [SIGN_W-1:0] bits,
			logic [NORM_W-1:0] norm, logic last);
		sketch_item_t it;
		it = random_item();
		it.op = OP_KEY;
		it.chunk = chunk;
		it.bits = bits;
		it.norm = norm;
		it.last = last;
		send_item(it);
	endtask

	// Drop valid and hold until every queued score has arrived, then let the pipe settle
	task automatic drain_scores();
		s_tvalid <= 1'b0;
		while (scorer.pending_scores.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_scale(logic [SCALE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		scorer.scale = v;
	endtask

	// Mostly whole keys in chunk order, with reordered keys and stray loads
	task automatic run_random(int count);
		int start;
		int r;
		int n;
		start = loads_sent + chunks_sent;
		while (loads_sent + chunks_sent - start < count) begin
			r = $urandom_range(99);
			if (r < 75) begin
				for (int c = 0; c < 4; c++) begin
					if ($urandom_range(99) < 12)
						send_load(QIDX_W'($urandom), random_query());
					send_chunk(CIDX_W'(c), random_signs(),
						(c == 3) ? random_norm() : 16'($urandom), c == 3);
				end
			end else if (r < 87) begin
				n = $urandom_range(6, 1);
				for (int k = 0; k < n; k++)
					send_chunk(CIDX_W'($urandom), random_signs(),
						(k == n - 1) ? random_norm() : 16'($urandom), k == n - 1);
			end else begin
				send_load(QIDX_W'($urandom), random_query());
			end
		end
	endtask

	initial begin
		logic [SIGN_W-1:0] b;
		scorer = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill the whole query store so no key reads an unwritten entry
		for (int i = 0; i < QUERY_LEN_DEF; i++)
			send_load(QIDX_W'(i), random_query());

		// Directed: extremes, reset scale, special norms
		send_load(8'd0, 16'h7FFF);
		send_load(8'd255, 16'h8000);
		for (int c = 0; c < 4; c++)
			send_chunk(CIDX_W'(c), '1, 16'h3F80, c == 3);
		send_chunk(2'd0, '0, 16'hBF80, 1'b1);
		// NaN norm
		send_chunk(2'd1, random_signs(), 16'h7FC1, 1'b1);
		// Infinite norm over a zero dot: a chunk and its complement cancel
		b = {$urandom, $urandom};
		send_chunk(2'd2, b, NORM_W'($urandom), 1'b0);
		send_chunk(2'd2, ~b, 16'h7F80, 1'b1);
		send_chunk(2'd3, random_signs(), 16'hFF80, 1'b1);
		// Subnormal and zero norms
		send_chunk(2'd1, random_signs(), 16'h0001, 1'b1);
		send_chunk(2'd2, random_signs(), 16'h0000, 1'b1);
		// Largest finite norm clips
		send_chunk(2'd0, '1, 16'h7F7F, 1'b1);
		// Dot of +-2 with norm 2^14 lands exactly on a half: rounding ties both ways
		send_load(8'd0, 16'h0001);
		for (int t = 0; t < 2; t++) begin
			b = {$urandom, $urandom};
			b[0] = 1'(t);
			send_chunk(2'd0, b, NORM_W'($urandom), 1'b0);
			send_chunk(2'd0, ~b ^ 64'h1, 16'h4680, 1'b1);
		end
		drain_scores();

		write_scale(16'hFFFF);
		run_random(190);
		drain_scores();

		write_scale(16'h0000);
		run_random(110);
		drain_scores();

		// No idling on either side
		write_scale(16'h0001);
		steady = 1'b1;
		run_random(110);
		drain_scores();
		steady = 1'b0;

		// Receiver holds off while the sender keeps offering
		write_scale(SCALE_W'($urandom));
		hold_req = 1'b1;
		run_random(190);
		drain_scores();

		write_scale(SCALE_RST);
		run_random(225);
		drain_scores();

		if (scorer.pending_scores.size() != 0)
			scorer.report($sformatf("%0d scores never arrived", scorer.pending_scores.size()));
		$display("Ran %0d query loads and %0d key chunks across six scale settings (0 and 65535 too)",
			loads_sent, chunks_sent);
		$display("Checked %0d scores, %0d of them clipped or special", scorer.scores_seen,
			scorer.clipped_seen);
		if (scorer.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
